### hw/rtl/dlip_pkg.sv
// Shared types and character codes for the decimal line input parser.
// No dependencies.
`timescale 1ns / 1ps

package dlip_pkg;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DEL   = 8'h7f;

   localparam int MAG_W = 15;
   localparam int VAL_W = 16;

   localparam logic [MAG_W-1:0] MAG_LIMIT_HI = 15'd3277;
   localparam logic [MAG_W-1:0] MAG_EDGE     = 15'd3276;
   localparam logic [3:0]       DIGIT_EDGE   = 4'd7;

   // floor(m / 10) == (m * DIV10_MUL) >> DIV10_SHIFT for all 15-bit m
   localparam logic [15:0] DIV10_MUL   = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef enum logic [1:0] {
      CMD_ECHO,
      CMD_RUB,
      CMD_VALUE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         echo_byte;
      logic [VAL_W-1:0]   value;
   } cmd_type;

endpackage

### hw/rtl/dlip_front.sv
// Front end: accepts characters, keeps magnitude and sign, issues commands.
// Depends on dlip_pkg.
`timescale 1ns / 1ps

module dlip_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_char_in,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              push,
   output dlip_pkg::cmd_type push_cmd
);
   import dlip_pkg::*;

   logic [MAG_W-1:0] magnitude_ff, magnitude_in;
   logic             negative_ff, negative_in;
   logic             accept;
   logic             is_cr, is_digit, is_rub, is_minus;
   logic [3:0]       digit;
   logic             take;
   logic [MAG_W-1:0] mag_times10;
   logic [31:0]      div_prod;
   logic [MAG_W-1:0] mag_div10;
   logic [VAL_W-1:0] mag_ext;
   logic             has_cmd;
   cmd_type          cmd;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign is_cr    = (req_char_in == CH_CR) || (req_char_in == CH_LF);
   assign is_digit = (req_char_in >= CH_ZERO) && (req_char_in <= CH_NINE);
   assign is_rub   = (req_char_in == CH_BS) || (req_char_in == CH_DEL);
   assign is_minus = (req_char_in == CH_MINUS);
   assign digit    = req_char_in[3:0];

   assign take = (magnitude_ff < MAG_LIMIT_HI) &&
                 !((magnitude_ff >= MAG_EDGE) && (digit > DIGIT_EDGE));

   assign mag_times10 = {magnitude_ff[MAG_W-4:0], 3'b000}
                      + {magnitude_ff[MAG_W-2:0], 1'b0}
                      + MAG_W'(digit);
   assign div_prod    = 32'(magnitude_ff) * 32'(DIV10_MUL);
   assign mag_div10   = MAG_W'(div_prod[31:DIV10_SHIFT]);
   assign mag_ext     = {1'b0, magnitude_ff};

   always_comb begin
      magnitude_in  = magnitude_ff;
      negative_in   = negative_ff;
      has_cmd       = 1'b0;
      cmd.kind      = CMD_ECHO;
      cmd.echo_byte = req_char_in;
      cmd.value     = '0;
      priority if (is_digit) begin
         if (take) begin
            magnitude_in = mag_times10;
            has_cmd      = 1'b1;
         end
      end else if (is_rub) begin
         cmd.kind      = CMD_RUB;
         cmd.echo_byte = CH_BS;
         if (magnitude_ff != '0) begin
            magnitude_in = mag_div10;
            has_cmd      = 1'b1;
         end else if (negative_ff) begin
            negative_in = 1'b0;
            has_cmd     = 1'b1;
         end
      end else if (is_minus) begin
         if (magnitude_ff == '0) begin
            negative_in = 1'b1;
            has_cmd     = 1'b1;
         end
      end else if (is_cr) begin
         cmd.kind      = CMD_VALUE;
         cmd.echo_byte = '0;
         cmd.value     = negative_ff ? (VAL_W'(0) - mag_ext) : mag_ext;
         magnitude_in  = '0;
         negative_in   = 1'b0;
         has_cmd       = 1'b1;
      end else begin
         has_cmd = 1'b0;
      end
   end

   assign push     = accept && has_cmd;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         magnitude_ff <= '0;
         negative_ff  <= 1'b0;
      end else if (accept) begin
         magnitude_ff <= magnitude_in;
         negative_ff  <= negative_in;
      end
   end

endmodule

### hw/rtl/dlip_queue.sv
// Short command queue between front and back end.
// Depends on dlip_pkg.
`timescale 1ns / 1ps

module dlip_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dlip_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output dlip_pkg::cmd_type head_cmd
);
   import dlip_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/dlip_back.sv
// Back end: expands queued commands into result items, one per cycle while rsp_stall is low.
// Depends on dlip_pkg.
`timescale 1ns / 1ps

module dlip_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  dlip_pkg::cmd_type             head_cmd,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [7:0]                    rsp_echo_byte,
   output logic signed [dlip_pkg::VAL_W-1:0] rsp_value,
   output logic                          rsp_last
);
   import dlip_pkg::*;

   logic             valid_ff;
   logic             kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             last_ff, last_in;
   logic [1:0]       step_ff;
   logic             load;

   assign load = !valid_ff || !rsp_stall;
   assign pop  = load && head_valid && last_in;

   always_comb begin
      kind_in  = 1'b0;
      byte_in  = head_cmd.echo_byte;
      value_in = '0;
      last_in  = 1'b1;
      unique case (head_cmd.kind)
         CMD_ECHO: begin
            last_in = 1'b1;
         end
         CMD_RUB: begin
            byte_in = (step_ff == 2'd1) ? CH_SPACE : CH_BS;
            last_in = (step_ff == 2'd2);
         end
         CMD_VALUE: begin
            kind_in  = 1'b1;
            byte_in  = '0;
            value_in = head_cmd.value;
         end
         default: begin
            last_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else if (load) begin
         valid_ff <= head_valid;
         if (head_valid) begin
            step_ff <= last_in ? 2'd0 : step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_echo_byte = byte_ff;
   assign rsp_value     = value_ff;
   assign rsp_last      = last_ff;

endmodule

### hw/rtl/decimal_line_input_parser.sv
// Top level of the decimal line input parser: front end, command queue, back end.
// Depends on dlip_pkg, dlip_front, dlip_queue, dlip_back.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_char_in       | in
//   rsp     | rsp_valid, rsp_stall, rsp_kind,         | out
//           | rsp_echo_byte, rsp_value, rsp_last      |
//
// An accepted request's command is written into the command queue, then loaded into the output register.
// Results leave at one per cycle while rsp_stall is low: one per digit, minus or line end, three per rubout.
// Sustained rate is set by the back end's single output register.
// Reset (synchronous, active high) clears magnitude, sign, queue and output valid.
// req_stall rises only when the command queue is full; rsp_stall holds the output register.
`timescale 1ns / 1ps

module decimal_line_input_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_char_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [7:0]                        rsp_echo_byte,
   output logic signed [dlip_pkg::VAL_W-1:0] rsp_value,
   output logic                              rsp_last
);
   import dlip_pkg::*;

   logic    push, queue_full, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   dlip_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_char_in (req_char_in),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   dlip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   dlip_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_echo_byte (rsp_echo_byte),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last)
   );

   a_value_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last && (rsp_echo_byte == 8'h00))
      else $error("value result not marked last or has echo byte");

   a_echo_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> (rsp_value == '0))
      else $error("echo result carries a value");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full queue");

endmodule

### bench/decimal_line_input_parser_test.sv
// Testbench for decimal_line_input_parser: directed table, then random lines.
// Random lines and BY_MODEL rows are checked against a built-in model; other rows against the table.
// Depends on dlip_pkg and the decimal_line_input_parser RTL.
`timescale 1ns / 1ps

module decimal_line_input_parser_test;
   import dlip_pkg::*;

   localparam logic KIND_ECHO  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;
   localparam int   QUIET_LIMIT = 2000;
   localparam int   RANDOM_LINES_ITEMS = 232;
   localparam int   HOLD_CYCLES = 120;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              echo_byte;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } parser_out_type;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_RESULT,
      ECHO_IS,
      VALUE_IS
   } row_check_type;

   typedef struct packed {
      logic [7:0]              ch;
      row_check_type           check;
      logic [7:0]              echo_byte;
      logic signed [VAL_W-1:0] value;
   } script_row_type;

   localparam int SCRIPT_LEN = 28;

   script_row_type script [SCRIPT_LEN] = '{
      '{CH_CR,          VALUE_IS,  8'h00,    16'sd0},
      '{CH_BS,          NO_RESULT, 8'h00,    16'sd0},
      '{CH_DEL,         NO_RESULT, 8'h00,    16'sd0},
      '{CH_MINUS,       ECHO_IS,   CH_MINUS, 16'sd0},
      '{CH_MINUS,       ECHO_IS,   CH_MINUS, 16'sd0},
      '{CH_LF,          VALUE_IS,  8'h00,    16'sd0},
      '{CH_ZERO,        ECHO_IS,   CH_ZERO,  16'sd0},
      '{CH_ZERO + 8'd3, BY_MODEL,  8'h00,    16'sd0},
      '{CH_ZERO + 8'd2, BY_MODEL,  8'h00,    16'sd0},
      '{CH_ZERO + 8'd7, BY_MODEL,  8'h00,    16'sd0},
      '{CH_ZERO + 8'd6, BY_MODEL,  8'h00,    16'sd0},
      '{CH_ZERO + 8'd8, NO_RESULT, 8'h00,    16'sd0},
      '{CH_NINE,        NO_RESULT, 8'h00,    16'sd0},
      '{CH_ZERO + 8'd7, ECHO_IS,   8'h37,    16'sd0},
      '{CH_ZERO,        NO_RESULT, 8'h00,    16'sd0},
      '{CH_CR,          VALUE_IS,  8'h00,    16'sd32767},
      '{CH_MINUS,       ECHO_IS,   CH_MINUS, 16'sd0},
      '{CH_ZERO + 8'd5, ECHO_IS,   8'h35,    16'sd0},
      '{CH_MINUS,       NO_RESULT, 8'h00,    16'sd0},
      '{CH_BS,          BY_MODEL,  8'h00,    16'sd0},
      '{CH_DEL,         BY_MODEL,  8'h00,    16'sd0},
      '{8'hff,          NO_RESULT, 8'h00,    16'sd0},
      '{8'h00,          NO_RESULT, 8'h00,    16'sd0},
      '{CH_MINUS,       BY_MODEL,  8'h00,    16'sd0},
      '{CH_NINE,        BY_MODEL,  8'h00,    16'sd0},
      '{CH_ZERO + 8'd1, BY_MODEL,  8'h00,    16'sd0},
      '{CH_BS,          BY_MODEL,  8'h00,    16'sd0},
      '{CH_LF,          VALUE_IS,  8'h00,    -16'sd9}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_char_in = 8'h00;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_kind;
   logic [7:0]              rsp_echo_byte;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_last;

   logic [MAG_W-1:0] line_mag = '0;
   logic             line_neg = 1'b0;
   parser_out_type   parsed [3];
   parser_out_type   awaited_outputs [$];
   logic [7:0]       boundary_run [$];

   int error_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int parsed_count;
   int busy_items;

   decimal_line_input_parser uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_echo_byte (rsp_echo_byte),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // Advances the line state by one character; returns the number of outputs in parsed.
   function automatic int parse_char(input logic [7:0] ch_in);
      logic [7:0]       ch;
      logic [3:0]       digit;
      logic [VAL_W-1:0] v;
      int               n;
      ch = (ch_in == CH_LF) ? CH_CR : ch_in;
      n = 0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         digit = 4'(ch - CH_ZERO);
         if (!(line_mag >= MAG_LIMIT_HI || (line_mag >= MAG_EDGE && digit > DIGIT_EDGE))) begin
            line_mag = MAG_W'(int'(line_mag) * 10 + int'(digit));
            parsed[n] = '{KIND_ECHO, ch, '0, 1'b0};
            n++;
         end
      end else if (ch == CH_BS || ch == CH_DEL) begin
         if (line_mag != 0 || line_neg) begin
            if (line_mag != 0)
               line_mag = line_mag / 10;
            else
               line_neg = 1'b0;
            parsed[0] = '{KIND_ECHO, CH_BS, '0, 1'b0};
            parsed[1] = '{KIND_ECHO, CH_SPACE, '0, 1'b0};
            parsed[2] = '{KIND_ECHO, CH_BS, '0, 1'b0};
            n = 3;
         end
      end else if (ch == CH_MINUS) begin
         if (line_mag == 0) begin
            line_neg = 1'b1;
            parsed[0] = '{KIND_ECHO, CH_MINUS, '0, 1'b0};
            n = 1;
         end
      end else if (ch == CH_CR) begin
         v = {1'b0, line_mag};
         if (line_neg)
            v = '0 - v;
         parsed[0] = '{KIND_VALUE, 8'h00, $signed(v), 1'b0};
         n = 1;
         line_mag = '0;
         line_neg = 1'b0;
      end
      if (n > 0)
         parsed[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic logic [7:0] next_line_char();
      int r;
      if (boundary_run.size() == 0) begin
         r = $urandom_range(99);
         if (r < 4) begin
            if ($urandom_range(1))
               boundary_run.push_back(CH_MINUS);
            boundary_run.push_back(CH_ZERO + 8'd3);
            boundary_run.push_back(CH_ZERO + 8'd2);
            boundary_run.push_back(CH_ZERO + 8'd7);
            boundary_run.push_back(CH_ZERO + 8'd6);
            boundary_run.push_back(CH_ZERO + 8'($urandom_range(9)));
            boundary_run.push_back(CH_ZERO + 8'($urandom_range(9)));
         end else if (r < 46)
            return CH_ZERO + 8'($urandom_range(9));
         else if (r < 53)
            return CH_MINUS;
         else if (r < 59)
            return CH_BS;
         else if (r < 62)
            return CH_DEL;
         else if (r < 69)
            return CH_CR;
         else if (r < 72)
            return CH_LF;
         else
            return 8'($urandom_range(255));
      end
      return boundary_run.pop_front();
   endfunction

   // Offers one request, waits for acceptance, then runs the model on it.
   task automatic send_char(input logic [7:0] ch, input row_check_type check,
                            input logic [7:0] echo_byte, input logic signed [VAL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= ch;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      parsed_count = parse_char(ch);
      case (check)
         BY_MODEL: begin
            for (int i = 0; i < parsed_count; i++)
               awaited_outputs.push_back(parsed[i]);
         end
         ECHO_IS:  awaited_outputs.push_back('{KIND_ECHO, echo_byte, '0, 1'b1});
         VALUE_IS: awaited_outputs.push_back('{KIND_VALUE, 8'h00, value, 1'b1});
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      parser_out_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outputs.size() == 0) begin
               $error("unexpected result: kind %0d echo_byte %02h value %0d last %0d",
                      rsp_kind, rsp_echo_byte, rsp_value, rsp_last);
               error_count++;
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  error_count++;
               end
               if (rsp_echo_byte !== want.echo_byte) begin
                  $error("echo_byte: expected %02h, got %02h", want.echo_byte, rsp_echo_byte);
                  error_count++;
               end
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_value);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++)
         send_char(script[i].ch, script[i].check, script[i].echo_byte, script[i].value);

      // long receiver hold-off while requests keep coming, so the input backs up
      hold_requests = hold_requests + 1;
      busy_items = 0;
      while (busy_items < RANDOM_LINES_ITEMS) begin
         case (busy_items * 4 / RANDOM_LINES_ITEMS)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 74;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct = 35;
            end
         endcase
         send_char(next_line_char(), BY_MODEL, 8'h00, '0);
         busy_items++;
      end
      req_valid <= 1'b0;

      while (awaited_outputs.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
